// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: command codes, the
// control word broadcast to the cell row and the read bus that runs along it.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned ILS_DEPTH       = 256;
  localparam int unsigned ILS_VALUE_WIDTH = 64;

  // Field widths of the request and result ports
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 9;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd7;

  // What every cell does in a given cycle
  typedef enum logic [2:0] {
    MD_HOLD  = 3'd0,  // keep the entry
    MD_WRITE = 3'd1,  // the cell at pos takes wdata
    MD_READ  = 3'd2,  // the cell at pos drives its entry onto the read bus
    MD_CLOSE = 3'd3,  // cells at and above pos take their upper neighbor
    MD_OPEN  = 3'd4,  // cells above pos take their lower neighbor, pos takes wdata
    MD_SWAP  = 3'd5   // pos takes wdata, pos2 takes wdata2
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos2;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] wdata2;
  } cell_ctrl_t;

  // One stage of the read bus, moving toward cell 0
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] data;
  } rd_bus_t;

endpackage

// File: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds a single entry, trades it with its neighbors when the
// list closes up or opens up, and keeps one stage of the read bus.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
#(
  parameter int unsigned IDX         = 0,
  parameter int unsigned VALUE_WIDTH = ILS_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  rd_bus_t                bus_i,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output rd_bus_t                bus_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  rd_bus_t                bus_q, bus_d;
  logic                   hit, hit2;

  assign hit  = (ctrl_i.pos == MY_POS);
  assign hit2 = (ctrl_i.pos2 == MY_POS);

  // Select the next entry from the broadcast command
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.mode)
      MD_WRITE: begin
        if (hit) entry_d = ctrl_i.wdata[VALUE_WIDTH-1:0];
      end
      MD_SWAP: begin
        if (hit) begin
          entry_d = ctrl_i.wdata[VALUE_WIDTH-1:0];
        end else if (hit2) begin
          entry_d = ctrl_i.wdata2[VALUE_WIDTH-1:0];
        end
      end
      MD_CLOSE: begin
        if (MY_POS >= ctrl_i.pos) entry_d = right_i;
      end
      MD_OPEN: begin
        if (MY_POS > ctrl_i.pos) begin
          entry_d = left_i;
        end else if (hit) begin
          entry_d = ctrl_i.wdata[VALUE_WIDTH-1:0];
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Inject on a read hit, otherwise pass the upper stage along
  always_comb begin
    bus_d = bus_i;
    if (ctrl_i.mode == MD_READ && hit) begin
      bus_d.vld  = 1'b1;
      bus_d.data = DATA_W'(entry_q);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else begin
      bus_q <= bus_d;
    end
  end

  assign entry_o = entry_q;
  assign bus_o   = bus_q;

endmodule

// File: rtl/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of up to DEPTH words kept in a row of cells, with push, get,
// set, pop, shift, remove, insert and swap commands.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd_i, index_i, second_index_i, value_i) is taken when
//   in_valid_i is high and in_stall_o is low. Each request yields exactly one
//   result (data_o, found_o, ok_o, count_o) on out_valid_o, taken when
//   out_stall_i is low. Results come out in request order.
//   Push, set, insert, an ignored swap and any read that misses do not use
//   the read bus: the result sits in the output register after the accepting
//   edge. Get, pop, shift and remove that hit wait for their word to come
//   back on the read bus; swap reads position p and then position q. The
//   read bus moves a word one cell toward cell 0 per cycle.
//   One request is in flight at a time; in_stall_o is high while a request is
//   being worked on or while the result register is full and stalled.
//   A stalled result holds its value until taken. Reset empties the list
//   (count 0) and drops any pending result; no clearing pass is needed.
//   count_o is the low 9 bits of the fill count after the command.
// ----------------------------------------------------------------------------
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH       = ILS_DEPTH,
  parameter int unsigned VALUE_WIDTH = ILS_VALUE_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic signed [POS_W-1:0] index_i,
  input  logic signed [POS_W-1:0] second_index_i,
  input  logic [DATA_W-1:0]  value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DATA_W-1:0]  data_o,
  output logic               found_o,
  output logic               ok_o,
  output logic [COUNT_W-1:0] count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WAIT1 = 2'd1;
  localparam logic [1:0] ST_WAIT2 = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [POS_W-1:0]   pos_q, pos_d, pos2_q, pos2_d;
  logic [DATA_W-1:0]  rd1_q, rd1_d, rd2_q, rd2_d;

  logic               out_vld_q;
  logic [DATA_W-1:0]  out_data_q, out_data_d;
  logic               out_found_q, out_found_d;
  logic               out_ok_q, out_ok_d;
  logic [COUNT_W-1:0] out_count_q;
  logic               load_out;

  cell_ctrl_t         ctrl;
  logic [VALUE_WIDTH-1:0] entry_w [DEPTH];
  rd_bus_t            bus_w [DEPTH+1];

  logic               accept, out_free, full;
  logic [POS_W-1:0]   idx_u, idx2_u, ins_pos, cnt_pos, last_pos;
  logic               in1, in2;
  logic [VALUE_WIDTH-1:0] val_w;

  // Decode request positions
  assign idx_u    = $unsigned(index_i);
  assign idx2_u   = $unsigned(second_index_i);
  assign cnt_pos  = POS_W'(count_q);
  assign last_pos = POS_W'(count_q - CW'(1));
  assign in1      = !idx_u[POS_W-1] && (idx_u < cnt_pos);
  assign in2      = !idx2_u[POS_W-1] && (idx2_u < cnt_pos);
  assign full     = (count_q >= CW'(DEPTH));
  assign ins_pos  = idx_u[POS_W-1] ? '0 : ((idx_u > cnt_pos) ? cnt_pos : idx_u);
  assign val_w    = value_i[VALUE_WIDTH-1:0];

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Sequence each request and drive the cell row
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    pos2_d      = pos2_q;
    rd1_d       = rd1_q;
    rd2_d       = rd2_q;
    load_out    = 1'b0;
    out_data_d  = '0;
    out_found_d = 1'b0;
    out_ok_d    = 1'b1;
    ctrl        = '0;
    ctrl.mode   = MD_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_i;
          pos2_d = idx2_u;
          case (cmd_i)
            CMD_PUSH: begin
              load_out = 1'b1;
              if (full) begin
                out_ok_d = 1'b0;
              end else begin
                ctrl.mode  = MD_WRITE;
                ctrl.pos   = cnt_pos;
                ctrl.wdata = DATA_W'(val_w);
                count_d    = count_q + CW'(1);
              end
            end
            CMD_SET: begin
              load_out = 1'b1;
              if (in1) begin
                ctrl.mode  = MD_WRITE;
                ctrl.pos   = idx_u;
                ctrl.wdata = DATA_W'(val_w);
              end
            end
            CMD_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                out_ok_d = 1'b0;
              end else begin
                ctrl.mode  = MD_OPEN;
                ctrl.pos   = ins_pos;
                ctrl.wdata = DATA_W'(val_w);
                count_d    = count_q + CW'(1);
              end
            end
            CMD_POP: begin
              if (count_q != '0) begin
                ctrl.mode = MD_READ;
                ctrl.pos  = last_pos;
                pos_d     = last_pos;
                state_d   = ST_WAIT1;
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_SHIFT: begin
              if (count_q != '0) begin
                ctrl.mode = MD_READ;
                ctrl.pos  = '0;
                pos_d     = '0;
                state_d   = ST_WAIT1;
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_SWAP: begin
              if (in1 && in2) begin
                ctrl.mode = MD_READ;
                ctrl.pos  = idx_u;
                pos_d     = idx_u;
                state_d   = ST_WAIT1;
              end else begin
                load_out = 1'b1;
              end
            end
            default: begin
              // get and remove
              if (in1) begin
                ctrl.mode = MD_READ;
                ctrl.pos  = idx_u;
                pos_d     = idx_u;
                state_d   = ST_WAIT1;
              end else begin
                load_out = 1'b1;
              end
            end
          endcase
        end
      end
      ST_WAIT1: begin
        if (bus_w[0].vld) begin
          rd1_d = bus_w[0].data;
          if (cmd_q == CMD_SWAP) begin
            ctrl.mode = MD_READ;
            ctrl.pos  = pos2_q;
            state_d   = ST_WAIT2;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WAIT2: begin
        if (bus_w[0].vld) begin
          rd2_d   = bus_w[0].data;
          state_d = ST_DONE;
        end
      end
      default: begin
        // finish the request once the result register can take it
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          case (cmd_q)
            CMD_SWAP: begin
              ctrl.mode   = MD_SWAP;
              ctrl.pos    = pos_q;
              ctrl.pos2   = pos2_q;
              ctrl.wdata  = rd2_q;
              ctrl.wdata2 = rd1_q;
            end
            CMD_GET: begin
              out_data_d  = rd1_q;
              out_found_d = 1'b1;
            end
            CMD_POP: begin
              out_data_d  = rd1_q;
              out_found_d = 1'b1;
              count_d     = count_q - CW'(1);
            end
            default: begin
              // shift and remove close up over the read slot
              out_data_d  = rd1_q;
              out_found_d = 1'b1;
              ctrl.mode   = MD_CLOSE;
              ctrl.pos    = pos_q;
              count_d     = count_q - CW'(1);
            end
          endcase
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    pos2_q <= pos2_d;
    rd1_q  <= rd1_d;
    rd2_q  <= rd2_d;
    if (load_out) begin
      out_data_q  <= out_data_d;
      out_found_q <= out_found_d;
      out_ok_q    <= out_ok_d;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  // Row of cells; the read bus enters empty above the last cell
  assign bus_w[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_w, right_w;

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = entry_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = entry_w[k+1];
    end

    ils_cell #(
      .IDX         (k),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .bus_i   (bus_w[k+1]),
      .entry_o (entry_w[k]),
      .bus_o   (bus_w[k])
    );
  end

  assign out_valid_o = out_vld_q;
  assign data_o      = out_data_q;
  assign found_o     = out_found_q;
  assign ok_o        = out_ok_q;
  assign count_o     = out_count_q;

endmodule
